### sv/solid_color_blend_composite_unit_defines.svh
// Assertion macros for the solid color blend composite unit.
// Included by the modules that check their own pipeline logic; no dependencies.
`ifndef SOLID_COLOR_BLEND_COMPOSITE_UNIT_DEFINES_SVH
`define SOLID_COLOR_BLEND_COMPOSITE_UNIT_DEFINES_SVH
`ifndef SYNTH
// property that must hold at every edge outside reset
`define SCB_ASSERT_HOLD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scb assertion failed");
// condition in one cycle implies consequence in the next
`define SCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scb assertion failed");
`else
`define SCB_ASSERT_HOLD(lbl, clk, rst_n, prop)
`define SCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/scb_pkg.sv
// Shared types, constants and arithmetic helpers for the solid color blend unit.
// No dependencies; imported by every module of the block.
package scb_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned Q_W      = 17;              // unsigned Q16, 0..1.0
    localparam logic [16:0] Q_ONE    = 17'h10000;
    localparam int unsigned PCT_MAX  = 100;
    localparam int unsigned M_W      = 16;              // 8x8 blend product
    localparam int unsigned B_W      = 25;              // blend value in Q16, up to 510.0
    localparam int unsigned CC_W     = 25;              // solid * opacity
    localparam int unsigned ACC_W    = 43;              // Q32 accumulator with rounding
    localparam int unsigned DIV_IN_W = 25;
    localparam int unsigned DIV_K    = 33;
    localparam logic [25:0] DIV_M    = 26'd33686019;    // ceil(2^33 / 255)

    // register map of the configuration port
    typedef enum logic [2:0] {
        REG_SOLID_RED   = 3'd0,
        REG_SOLID_GREEN = 3'd1,
        REG_SOLID_BLUE  = 3'd2,
        REG_SOURCE_OPA  = 3'd3,
        REG_SOLID_OPA   = 3'd4,
        REG_BLEND_MODE  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_MULTIPLY = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_ADD      = 2'd3
    } t_blend_mode;

    // live configuration, opacities already converted to Q16
    typedef struct packed {
        logic [NUM_CH-1:0][CHAN_W-1:0] solid;
        logic [Q_W-1:0]                so_q;
        logic [Q_W-1:0]                co_q;
        t_blend_mode                   mode;
    } t_cfg;

    // item leaving the front stages
    typedef struct packed {
        logic [NUM_CH-1:0][CHAN_W-1:0] pix;
        logic [Q_W-1:0]                sa;
        logic [NUM_CH-1:0][M_W-1:0]    m;
        logic [NUM_CH-1:0][CHAN_W-1:0] q;
    } t_front;

    // percent to Q16 lookup, saturating above 100
    typedef logic [Q_W-1:0] t_pct_tab [128];

    function automatic t_pct_tab build_pct_tab();
        t_pct_tab tab;
        int       p;
        for (int i = 0; i < 128; i++) begin
            p      = (i > PCT_MAX) ? PCT_MAX : i;
            tab[i] = Q_W'((p * 65536 + PCT_MAX / 2) / PCT_MAX);
        end
        return tab;
    endfunction

    localparam t_pct_tab PCT_Q16 = build_pct_tab();

    // floor(x / 255) by reciprocal multiply; exact for x below 255 * 2^17, where the quotient fits the result
    function automatic logic [Q_W-1:0] div255(input logic [DIV_IN_W-1:0] x);
        logic [50:0] prod;
        prod = 51'(x) * 51'(DIV_M);
        return prod[DIV_K+Q_W-1:DIV_K];
    endfunction

    // round half up from Q32 and clamp to 255
    function automatic logic [CHAN_W-1:0] round_q32(input logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] s;
        logic [10:0]      r;
        s = v + ACC_W'(64'h8000_0000);
        r = s[ACC_W-1:32];
        return (r > 11'd255) ? 8'hFF : r[CHAN_W-1:0];
    endfunction

endpackage

### sv/scb_cfg.sv
// Configuration register file: solid color, opacities (stored as Q16) and blend mode.
// Depends on scb_pkg.
module scb_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output scb_pkg::t_cfg o_cfg
);
    import scb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode one register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SOLID_RED:   n_cfg.solid[0] = i_cfg_data;
                REG_SOLID_GREEN: n_cfg.solid[1] = i_cfg_data;
                REG_SOLID_BLUE:  n_cfg.solid[2] = i_cfg_data;
                REG_SOURCE_OPA:  n_cfg.so_q     = PCT_Q16[i_cfg_data[6:0]];
                REG_SOLID_OPA:   n_cfg.co_q     = PCT_Q16[i_cfg_data[6:0]];
                REG_BLEND_MODE:  n_cfg.mode     = t_blend_mode'(i_cfg_data[1:0]);
                default:         n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.solid <= '0;
            r_cfg.so_q  <= Q_ONE;
            r_cfg.co_q  <= Q_ONE;
            r_cfg.mode  <= MODE_NORMAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### sv/scb_front.sv
// Front pipeline stages: source weight and the product terms of multiply/screen.
// Depends on scb_pkg and the assertion macro header.
`include "solid_color_blend_composite_unit_defines.svh"
module scb_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  scb_pkg::t_cfg                           i_cfg,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [3:0][scb_pkg::CHAN_W-1:0]         i_pix,   // red, green, blue, alpha
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output scb_pkg::t_front                         o_data
);
    import scb_pkg::*;

    logic                          r_v1;
    logic [NUM_CH-1:0][CHAN_W-1:0] r_pix1;
    logic [DIV_IN_W-1:0]           r_sax1;
    logic [NUM_CH-1:0][M_W-1:0]    r_m1;

    logic                          r_v2;
    logic [NUM_CH-1:0][CHAN_W-1:0] r_pix2;
    logic [Q_W-1:0]                r_sa2;
    logic [NUM_CH-1:0][M_W-1:0]    r_m2;
    logic [NUM_CH-1:0][CHAN_W-1:0] r_q2;

    logic w_en1;
    logic w_en2;

    // a stage moves when it is empty or its successor moves
    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    // stage 1: alpha * source opacity, per-channel 8x8 products
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_pix1 <= i_pix[2:0];
            r_sax1 <= DIV_IN_W'(i_pix[3]) * DIV_IN_W'(i_cfg.so_q) + DIV_IN_W'(127);
            for (int c = 0; c < NUM_CH; c++) begin
                if (i_cfg.mode == MODE_SCREEN) begin
                    r_m1[c] <= M_W'(8'hFF - i_pix[c]) * M_W'(8'hFF - i_cfg.solid[c]);
                end else begin
                    r_m1[c] <= M_W'(i_pix[c]) * M_W'(i_cfg.solid[c]);
                end
            end
        end
    end

    // stage 2: divide by 255 via reciprocal
    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_pix2 <= r_pix1;
            r_sa2  <= div255(r_sax1);
            r_m2   <= r_m1;
            for (int c = 0; c < NUM_CH; c++) begin
                r_q2[c] <= CHAN_W'(div255(DIV_IN_W'(r_m1[c]) + DIV_IN_W'(127)));
            end
        end
    end

    assign o_data.pix = r_pix2;
    assign o_data.sa  = r_sa2;
    assign o_data.m   = r_m2;
    assign o_data.q   = r_q2;

    `SCB_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, r_v2 && !i_ready, r_v2)
    `SCB_ASSERT_HOLD(a_sa_range, i_clk, i_rst_n, r_v2 |-> (r_sa2 <= Q_ONE))

endmodule

### sv/scb_mix.sv
// Back pipeline stages: blend value, weighted mix, alpha coverage, rounding.
// Depends on scb_pkg and the assertion macro header.
`include "solid_color_blend_composite_unit_defines.svh"
module scb_mix (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scb_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  scb_pkg::t_front                 i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [3:0][scb_pkg::CHAN_W-1:0] o_pix    // red, green, blue, alpha
);
    import scb_pkg::*;

    logic                          r_v3;
    logic [NUM_CH-1:0][B_W-1:0]    r_b3;
    logic [NUM_CH-1:0][CC_W-1:0]   r_cc3;
    logic [Q_W-1:0]                r_sa3;
    logic [Q_W-1:0]                r_nsa3;
    logic [Q_W:0]                  r_ss3;
    logic [2*Q_W-1:0]              r_sc3;

    logic                          r_v4;
    logic [NUM_CH-1:0][41:0]       r_pa4;
    logic [NUM_CH-1:0][41:0]       r_pb4;
    logic [41:0]                   r_av4;

    logic                          r_v5;
    logic [3:0][CHAN_W-1:0]        r_pix5;

    logic w_en3;
    logic w_en4;
    logic w_en5;
    logic [2*Q_W-1:0]              w_cov;
    logic [NUM_CH-1:0][B_W-1:0]    w_mb;

    assign w_en5   = !r_v5 || i_ready;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;
    assign o_valid = r_v5;
    assign o_pix   = r_pix5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en3) r_v3 <= i_valid;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // m*65536/255 rounded = m*257 + (m+127)/255
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_mb[c] = B_W'({i_data.m[c], 8'h00}) + B_W'(i_data.m[c]) + B_W'(i_data.q[c]);
        end
    end

    // stage 3: blend value per mode, solid weight, coverage product
    always_ff @(posedge i_clk) begin
        if (w_en3 && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                case (i_cfg.mode)
                    MODE_MULTIPLY: r_b3[c] <= w_mb[c];
                    MODE_SCREEN:   r_b3[c] <= B_W'({8'hFF, 16'h0000}) - w_mb[c];
                    MODE_ADD:      r_b3[c] <= B_W'({9'(i_data.pix[c]) + 9'(i_cfg.solid[c]),
                                                   16'h0000});
                    default:       r_b3[c] <= B_W'({i_data.pix[c], 16'h0000});
                endcase
                r_cc3[c] <= CC_W'(i_cfg.solid[c]) * CC_W'(i_cfg.co_q);
            end
            r_sa3  <= i_data.sa;
            r_nsa3 <= Q_ONE - i_data.sa;
            r_ss3  <= (Q_W+1)'(i_data.sa) + (Q_W+1)'(i_cfg.co_q);
            r_sc3  <= (2*Q_W)'(i_data.sa) * (2*Q_W)'(i_cfg.co_q);
        end
    end

    // coverage in Q32: (sa + co) * 2^16 - sa*co
    assign w_cov = {r_ss3, 16'h0000} - r_sc3;

    // stage 4: weighted products, alpha times 255
    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_pa4[c] <= 42'(r_cc3[c]) * 42'(r_nsa3);
                r_pb4[c] <= 42'(r_b3[c]) * 42'(r_sa3);
            end
            r_av4 <= {w_cov, 8'h00} - 42'(w_cov);
        end
    end

    // stage 5: sum, round and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (w_en5 && r_v4) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_pix5[c] <= round_q32(ACC_W'(r_pa4[c]) + ACC_W'(r_pb4[c]));
            end
            r_pix5[3] <= round_q32(ACC_W'(r_av4));
        end
    end

    `SCB_ASSERT_NEXT(a_mix_advance, i_clk, i_rst_n, r_v4 && w_en5, r_v5)
    `SCB_ASSERT_HOLD(a_weight_sum, i_clk, i_rst_n, r_v3 |-> ((18'(r_nsa3) + 18'(r_sa3)) == 18'h10000))

endmodule

### sv/solid_color_blend_composite_unit.sv
// Top level of the solid color blend composite unit.
// Depends on scb_pkg, scb_cfg, scb_front and scb_mix.
//
// Usage:
//   s_axis_*  : one RGBA source pixel per item (tdata = red, green, blue, alpha
//               from bit 0 up). m_axis_* : one composited RGBA pixel per item,
//               same packing.
//   i_cfg_*   : register writes (index 0..5: solid red, green, blue, source
//               opacity %, solid opacity %, blend mode); ready is always high,
//               writes to other indexes are dropped. Write only while idle.
//   Pipeline  : an accepted item passes five register stages (two front, three
//               mix) before it shows on m_axis_tvalid and m_axis_tdata.
//   Throughput: one item per clock when not stalled; every stage has its own
//               valid bit and moves whenever it is empty or the stage after it moves.
//   Reset     : synchronous, active low; pipeline emptied, solid color black,
//               both opacities 100 %, blend mode normal.
//   Stall     : when m_axis_tready is low the last stage holds its item and
//               empty stages ahead of it still fill, so up to five items are
//               taken before s_axis_tready drops. Nothing is lost or repeated.
module solid_color_blend_composite_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import scb_pkg::*;

    t_cfg                   w_cfg;
    t_front                 w_front;
    logic                   w_front_valid;
    logic                   w_mix_ready;
    logic [3:0][CHAN_W-1:0] w_in_pix;
    logic [3:0][CHAN_W-1:0] w_out_pix;

    assign w_in_pix     = s_axis_tdata;
    assign m_axis_tdata = w_out_pix;

    scb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    scb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (w_in_pix),
        .o_valid (w_front_valid),
        .i_ready (w_mix_ready),
        .o_data  (w_front)
    );

    scb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_front_valid),
        .o_ready (w_mix_ready),
        .i_data  (w_front),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (w_out_pix)
    );

endmodule

### tb/solid_color_blend_composite_unit_tb.sv
// Testbench for the solid color blend composite unit: drives RGBA pixels and
// register writes, predicts each composited pixel and compares it per channel.
// Depends on scb_pkg and solid_color_blend_composite_unit.
`timescale 1ns / 100ps

module solid_color_blend_composite_unit_tb;
    import scb_pkg::*;

    // unused register indexes, writes there must be dropped
    localparam logic [2:0] REG_IDX_SPARE_A = 3'd6;
    localparam logic [2:0] REG_IDX_SPARE_B = 3'd7;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         PHASE_ITEMS     = 200;

    // one RGBA pixel, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // in_red, in_green, in_blue, in_alpha
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // out_red, out_green, out_blue, out_alpha
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [7:0]  i_cfg_data    = '0;

    // shadow copy of the layer registers
    logic [7:0]  layer_red;
    logic [7:0]  layer_green;
    logic [7:0]  layer_blue;
    logic [6:0]  src_opa_pct;
    logic [6:0]  layer_opa_pct;
    t_blend_mode blend_sel;

    t_pixel      pending_pixels[$];
    int          mismatch_count = 0;
    bit          no_idle        = 1'b0;

    solid_color_blend_composite_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------- prediction ----------------

    // percent to Q16, saturating above 100
    function automatic longint unsigned pct_q16(input logic [6:0] pct);
        longint unsigned p;
        p = (pct > 7'd100) ? 64'd100 : 64'(pct);
        return (p * 65536 + 50) / 100;
    endfunction

    // Q32 to 8 bits, round half up, clamp high
    function automatic logic [7:0] round_clamp(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'h8000_0000) >> 32;
        return (r > 255) ? 8'hFF : r[7:0];
    endfunction

    // blend of pixel and layer channel in Q16
    function automatic longint unsigned blend_q16(input longint unsigned p,
                                                  input longint unsigned c);
        case (blend_sel)
            MODE_MULTIPLY: return (p * c * 65536 + 127) / 255;
            MODE_SCREEN:   return 255 * 65536 - ((255 - p) * (255 - c) * 65536 + 127) / 255;
            MODE_ADD:      return (p + c) << 16;
            default:       return p << 16;
        endcase
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] p, input logic [7:0] c,
                                            input longint unsigned co,
                                            input longint unsigned sa);
        longint unsigned pv;
        longint unsigned cv;
        pv = 64'(p);
        cv = 64'(c);
        return round_clamp(cv * co * (65536 - sa) + blend_q16(pv, cv) * sa);
    endfunction

    // expected output pixel under the current layer settings
    function automatic t_pixel composite_pixel(input t_pixel px);
        longint unsigned so;
        longint unsigned co;
        longint unsigned sa;
        t_pixel          res;
        so        = pct_q16(src_opa_pct);
        co        = pct_q16(layer_opa_pct);
        sa        = (64'(px.alpha) * so + 127) / 255;
        res.red   = mix_chan(px.red,   layer_red,   co, sa);
        res.green = mix_chan(px.green, layer_green, co, sa);
        res.blue  = mix_chan(px.blue,  layer_blue,  co, sa);
        res.alpha = round_clamp(255 * (sa * 65536 + co * 65536 - sa * co));
        return res;
    endfunction

    // ---------------- output side ----------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // output ready, random stall per item
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(3, 0);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    // compare each output item with the oldest prediction
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected output item %h", got));
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                if (got.alpha !== want.alpha)
                    report_mismatch($sformatf("alpha %0d, want %0d", got.alpha, want.alpha));
            end
        end
    end

    // ---------------- input side ----------------

    // send one pixel after a random gap; valid stays high into a gapless next item
    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(3, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(composite_pixel(px));
    endtask

    task automatic send_rgba(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.alpha = a;
        send_pixel(px);
    endtask

    // stop sending and wait until every predicted pixel is out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // one register write; valid is only dropped after the last of a burst
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SOLID_RED:   layer_red     = val;
            REG_SOLID_GREEN: layer_green   = val;
            REG_SOLID_BLUE:  layer_blue    = val;
            REG_SOURCE_OPA:  src_opa_pct   = val[6:0];
            REG_SOLID_OPA:   layer_opa_pct = val[6:0];
            REG_BLEND_MODE:  blend_sel     = t_blend_mode'(val[1:0]);
            default: ;
        endcase
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // full layer setup, only called with the pipe drained
    task automatic set_layer(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] so, input logic [7:0] co,
                             input logic [7:0] mode);
        write_reg(REG_SOLID_RED,   r,    1'b0);
        write_reg(REG_SOLID_GREEN, g,    1'b0);
        write_reg(REG_SOLID_BLUE,  b,    1'b0);
        write_reg(REG_SOURCE_OPA,  so,   1'b0);
        write_reg(REG_SOLID_OPA,   co,   1'b0);
        write_reg(REG_BLEND_MODE,  mode, 1'b1);
    endtask

    // opacity byte: low bits mostly edges and the legal range, sometimes above 100; top bit random
    function automatic logic [7:0] rand_opacity();
        logic [7:0] v;
        case ($urandom_range(3, 0))
            0:       v = 8'd0;
            1:       v = 8'd100;
            2:       v = 8'($urandom_range(255, 0));
            default: v = 8'($urandom_range(100, 0));
        endcase
        v[7] = 1'($urandom_range(1, 0));
        return v;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px = $urandom();
        case ($urandom_range(7, 0))
            0:       px.alpha = 8'h00;
            1:       px.alpha = 8'hFF;
            default: ;
        endcase
        return px;
    endfunction

    // ---------------- tests ----------------

    task automatic apply_reset();
        layer_red     = 8'd0;
        layer_green   = 8'd0;
        layer_blue    = 8'd0;
        src_opa_pct   = 7'd100;
        layer_opa_pct = 7'd100;
        blend_sel     = MODE_NORMAL;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // reset settings: black layer, full opacity, normal mode
    task automatic test_reset_defaults();
        send_rgba(8'h00, 8'h00, 8'h00, 8'h00);
        send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_rgba(8'hFF, 8'h80, 8'h01, 8'h80);
        wait_drained();
    endtask

    // each blend mode; add overflows and clamps on red
    task automatic test_blend_modes();
        t_blend_mode m;
        m = m.first();
        forever begin
            set_layer(8'd200, 8'd0, 8'd255, 8'd100, 8'd60, 8'(m));
            send_rgba(8'd200, 8'd255, 8'd0,   8'd255);
            send_rgba(8'd55,  8'd128, 8'd255, 8'd128);
            send_rgba(8'd255, 8'd0,   8'd1,   8'd0);
            wait_drained();
            if (m == m.last())
                break;
            m = m.next();
        end
    endtask

    // opacity above one hundred saturates, top bit of the byte is dropped; then both opacities zero
    task automatic test_opacity_limits();
        set_layer(8'd255, 8'd255, 8'd255, 8'hFF, 8'd101, 8'(MODE_ADD));
        send_rgba(8'd10,  8'd250, 8'd128, 8'd255);
        send_rgba(8'd255, 8'd0,   8'd77,  8'd100);
        wait_drained();
        set_layer(8'd90, 8'd180, 8'd30, 8'd0, 8'd0, 8'(MODE_SCREEN));
        send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        send_rgba(8'd1,   8'd2,   8'd3,   8'd4);
        wait_drained();
    endtask

    // writes to unused indexes change nothing
    task automatic test_spare_index();
        set_layer(8'd17, 8'd34, 8'd51, 8'd70, 8'd30, 8'(MODE_MULTIPLY));
        write_reg(REG_IDX_SPARE_A, 8'hFF, 1'b0);
        write_reg(REG_IDX_SPARE_B, 8'hAA, 1'b1);
        send_rgba(8'd240, 8'd16, 8'd128, 8'd200);
        send_rgba(8'd255, 8'd255, 8'd0,  8'd255);
        wait_drained();
    endtask

    // random pixels over several layer settings, one mid-phase pause each
    task automatic test_random_stream();
        int pause_at;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            no_idle = (ph == 2);
            case (ph)
                0:       set_layer(8'hFF, 8'hFF, 8'hFF, 8'd100, 8'd100, 8'(MODE_ADD));
                1:       set_layer(8'h00, 8'h00, 8'h00, 8'd0,   8'd0,   8'(MODE_NORMAL));
                default: set_layer(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                   8'($urandom_range(255, 0)), rand_opacity(), rand_opacity(),
                                   8'($urandom_range(255, 0)));
            endcase
            pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at)
                    wait_drained();
                send_pixel(rand_pixel());
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        apply_reset();
        test_reset_defaults();
        test_blend_modes();
        test_opacity_limits();
        test_spare_index();
        test_random_stream();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/scb_pkg.sv
sv/scb_cfg.sv
sv/scb_front.sv
sv/scb_mix.sv
sv/solid_color_blend_composite_unit.sv
tb/solid_color_blend_composite_unit_tb.sv
